/* design/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants shared by the linear-probing hash table and its testbench.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 31;
	localparam int SIZE_W      = 7;

	localparam int MOD_BITS    = 4;
	localparam int DIV_W       = 32;
	localparam int MOD_STEPS   = DIV_W / MOD_BITS;
	localparam int STEP_W      = $clog2(MOD_STEPS);

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_READ,
		S_CHECK,
		S_RESP
	} state_t;

endpackage

/* design/linear_probe_hash_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// From the input transfer to a valid result: the home slot modulo, taken
// MOD_BITS key bits per step, then for each probed slot a key RAM read and
// a compare, then the load of the result register. A refused insert on a
// full table goes straight to the result register. One operation at a time;
// the next transfer is taken while the previous result waits at the output.
// Reset clears all slot valid bits and the entry count at once; table size 64.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lpht_pkg::SIZE_W-1:0]     cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [lpht_pkg::KEY_W-1:0]      key,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [lpht_pkg::SLOT_W-1:0]     slot_index
);

	import lpht_pkg::*;

	state_t             state_q, state_d;
	logic [SIZE_W-1:0]  tsize_q;
	logic [CNT_W-1:0]   n_c, n_q;
	logic [CNT_W-1:0]   count_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic               op_q;
	logic [KEY_W-1:0]   key_q;
	logic [DIV_W-1:0]   div_q;
	logic [SLOT_W-1:0]  rem_q, rem_c;
	logic [STEP_W-1:0]  step_q;
	logic [SLOT_W-1:0]  pos_q, pos_next;
	logic [CNT_W-1:0]   probes_q;
	logic [KEY_W-1:0]   ram_rdata;
	status_t            res_status_q, res_status_c;
	logic [SLOT_W-1:0]  res_slot_q, res_slot_c;
	status_t            out_status_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic               out_valid_q;
	logic               full_c, slot_empty, key_match, last_probe, do_write, check_done;
	logic               mod_last, out_load;

	// Effective size: zero is taken as one, anything above the depth as the depth.
	always_comb begin
		if (tsize_q == '0) begin
			n_c = CNT_W'(1);
		end else if (32'(tsize_q) > TABLE_DEPTH) begin
			n_c = CNT_W'(TABLE_DEPTH);
		end else begin
			n_c = CNT_W'(tsize_q);
		end
	end

	assign full_c = (op == OP_INSERT) && (count_q >= n_c);

	// Restoring remainder, MOD_BITS key bits per cycle.
	always_comb begin
		logic [CNT_W:0] r;
		r = (CNT_W+1)'(rem_q);
		for (int i = 0; i < MOD_BITS; i++) begin
			r = {r[CNT_W-1:0], div_q[DIV_W-1-i]};
			if (r >= (CNT_W+1)'(n_q)) begin
				r = r - (CNT_W+1)'(n_q);
			end
		end
		rem_c = r[SLOT_W-1:0];
	end

	assign mod_last = (step_q == STEP_W'(MOD_STEPS - 1));

	always_comb begin
		logic [CNT_W-1:0] p;
		p = CNT_W'(pos_q) + CNT_W'(1);
		pos_next = (p >= n_q) ? '0 : p[SLOT_W-1:0];
	end

	assign slot_empty = !valid_q[pos_q];
	assign key_match  = !slot_empty && (ram_rdata == key_q);
	assign last_probe = (probes_q == n_q - CNT_W'(1));

	lpht_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (do_write),
		.waddr(pos_q),
		.wdata(key_q),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = full_c ? S_RESP : S_MOD;
				end
			end
			S_MOD: begin
				if (mod_last) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = check_done ? S_RESP : S_READ;
			end
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		do_write     = 1'b0;
		check_done   = 1'b0;
		out_load     = 1'b0;
		res_status_c = ST_NOT_FOUND;
		res_slot_c   = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_CHECK: begin
				if (op_q == OP_INSERT) begin
					if (slot_empty) begin
						do_write     = 1'b1;
						check_done   = 1'b1;
						res_status_c = ST_INSERTED;
						res_slot_c   = pos_q;
					end else if (last_probe) begin
						check_done   = 1'b1;
						res_status_c = ST_FULL;
					end
				end else begin
					if (key_match) begin
						check_done   = 1'b1;
						res_status_c = ST_FOUND;
						res_slot_c   = pos_q;
					end else if (slot_empty || last_probe) begin
						check_done   = 1'b1;
					end
				end
			end
			S_RESP: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tsize_q     <= SIZE_RESET;
			count_q     <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				tsize_q <= cfg_wdata;
			end
			if (do_write) begin
				valid_q[pos_q] <= 1'b1;
				count_q        <= count_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q         <= op;
				key_q        <= key;
				n_q          <= n_c;
				div_q        <= DIV_W'(key);
				rem_q        <= '0;
				step_q       <= '0;
				res_status_q <= ST_FULL;
				res_slot_q   <= '0;
			end
			S_MOD: begin
				div_q    <= div_q << MOD_BITS;
				rem_q    <= rem_c;
				step_q   <= step_q + STEP_W'(1);
				pos_q    <= rem_c;
				probes_q <= '0;
			end
			S_CHECK: begin
				res_status_q <= res_status_c;
				res_slot_q   <= res_slot_c;
				if (!check_done) begin
					pos_q    <= pos_next;
					probes_q <= probes_q + CNT_W'(1);
				end
			end
			S_READ, S_RESP: begin
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign slot_index = out_slot_q;

endmodule

/* design/lpht_ram.sv */
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for linear_probe_hash_table. Insert and search transfers
// are offered in random bursts while the result side stalls on its own
// pattern, and two long hold-offs back the table up. Every accepted request
// is run through a local copy of the table, and each result is compared with
// the oldest outstanding prediction. The table size is changed between
// phases, from the degenerate single slot up past the full depth.
// ----------------------------------------------------------------------------
module testbench;

	import lpht_pkg::*;

	localparam int PHASE_ITEMS = 90;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 5000;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;

	typedef struct packed {
		logic             code;
		logic [KEY_W-1:0] key_val;
	} table_req_t;

	typedef struct packed {
		status_t           st;
		logic [SLOT_W-1:0] slot;
	} table_rsp_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cfg_we     = 1'b0;
	logic [SIZE_W-1:0]   cfg_wdata  = '0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic                op         = OP_INSERT;
	logic [KEY_W-1:0]    key        = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [1:0]          status;
	logic [SLOT_W-1:0]   slot_index;

	// Local copy of the table and of the size register.
	logic [KEY_W-1:0]    slot_key_copy [TABLE_DEPTH];
	logic                slot_used_copy [TABLE_DEPTH];
	int unsigned         occupied;
	logic [SIZE_W-1:0]   size_copy;

	table_req_t          pending_reqs [$];
	table_rsp_t          expected_rsps [$];
	logic [KEY_W-1:0]    issued_keys [$];

	int                  gap_left;
	int                  burst_left;
	int                  stall_mode;
	int                  mode_left;
	int                  hold_left;
	int                  rx_taken;
	int                  quiet_cycles;
	int                  error_count;
	int                  insert_count;
	int                  search_count;
	int                  size_settings;
	int                  outcome_count [4];
	status_t             pred_st;
	logic [SLOT_W-1:0]   pred_slot;
	table_rsp_t          oldest_rsp;

	linear_probe_hash_table u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.key        (key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot_index (slot_index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned slots_in_use();
		if (size_copy == '0)
			return 1;
		if (32'(size_copy) > TABLE_DEPTH)
			return TABLE_DEPTH;
		return 32'(size_copy);
	endfunction

	function automatic void probe_table(input logic code, input logic [KEY_W-1:0] k,
			output status_t st, output logic [SLOT_W-1:0] slot);
		int unsigned n;
		int unsigned pos;
		int unsigned i;
		bit done;
		n = slots_in_use();
		pos = 32'(k) % n;
		st = ST_NOT_FOUND;
		slot = '0;
		done = 1'b0;
		if (code == OP_INSERT) begin
			st = ST_FULL;
			if (occupied < n) begin
				for (i = 0; i < n && !done; i++) begin
					if (!slot_used_copy[pos]) begin
						slot_key_copy[pos] = k;
						slot_used_copy[pos] = 1'b1;
						occupied++;
						st = ST_INSERTED;
						slot = SLOT_W'(pos);
						done = 1'b1;
					end else begin
						pos = (pos + 1 >= n) ? 0 : pos + 1;
					end
				end
			end
		end else begin
			for (i = 0; i < n && !done; i++) begin
				if (!slot_used_copy[pos]) begin
					done = 1'b1;
				end else if (slot_key_copy[pos] == k) begin
					st = ST_FOUND;
					slot = SLOT_W'(pos);
					done = 1'b1;
				end else begin
					pos = (pos + 1 >= n) ? 0 : pos + 1;
				end
			end
		end
	endfunction

	task automatic add_req(input logic code, input logic [KEY_W-1:0] k);
		pending_reqs.push_back('{code: code, key_val: k});
		if (code == OP_INSERT)
			issued_keys.push_back(k);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_copy = v;
		size_settings++;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned n;
		int unsigned sel;
		int unsigned top;
		n = slots_in_use();
		sel = $urandom_range(0, 9);
		if (sel <= 2 || (sel <= 5 && issued_keys.size() == 0))
			return KEY_W'($urandom);
		if (sel <= 5)
			return issued_keys[$urandom_range(0, issued_keys.size() - 1)];
		top = 32'h7FFF_FFFF / n - 1;
		if (sel == 9)
			return KEY_W'(n * $urandom_range(0, top) + $urandom_range(0, (n > 4) ? 3 : n - 1));
		return KEY_W'(n * $urandom_range(0, 1000) + $urandom_range(0, (n > 4) ? 3 : n - 1));
	endfunction

	// Sender: pops pending requests, idling in random gaps between bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_INSERT;
			key <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				probe_table(op, key, pred_st, pred_slot);
				expected_rsps.push_back('{st: pred_st, slot: pred_slot});
				if (op == OP_INSERT)
					insert_count++;
				else
					search_count++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_reqs.size() != 0) begin
					in_valid <= 1'b1;
					op <= pending_reqs[0].code;
					key <= pending_reqs[0].key_val;
					void'(pending_reqs.pop_front());
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern changes at random, with two long hold-offs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
			hold_left <= 0;
			rx_taken <= 0;
		end else begin
			if (out_valid && out_ready)
				rx_taken <= rx_taken + 1;
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(16, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready && (rx_taken == 150 || rx_taken == 1000)) begin
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: begin
						out_ready <= 1'b1;
					end
					1: begin
						out_ready <= 1'($urandom_range(0, 1));
					end
					2: begin
						out_ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						out_ready <= ~out_ready;
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_rsps.size() == 0) begin
				$error("result transfer with nothing outstanding: status %0d slot_index %0d",
					status, slot_index);
				error_count++;
			end else begin
				oldest_rsp = expected_rsps.pop_front();
				outcome_count[oldest_rsp.st]++;
				if (status !== oldest_rsp.st) begin
					$error("status: expected %0d, actual %0d", oldest_rsp.st, status);
					error_count++;
				end
				if (slot_index !== oldest_rsp.slot) begin
					$error("slot_index: expected %0d, actual %0d", oldest_rsp.slot, slot_index);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [SIZE_W-1:0] phase_sizes [18];
		int p;
		int j;
		phase_sizes = '{7'd3, 7'd1, 7'd6, 7'd5, 7'd8, 7'd12, 7'd16, 7'd24, 7'd0, 7'd33,
			7'd48, 7'd64, 7'd100, 7'd127, 7'd7, 7'd64, 7'd40, 7'd64};
		for (j = 0; j < TABLE_DEPTH; j++) begin
			slot_key_copy[j] = '0;
			slot_used_copy[j] = 1'b0;
		end
		occupied = 0;
		size_copy = SIZE_RESET;
		error_count = 0;
		insert_count = 0;
		search_count = 0;
		size_settings = 0;
		quiet_cycles = 0;
		outcome_count = '{0, 0, 0, 0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Size after reset: empty searches, a store at the last slot, and a
		// duplicate that wraps round to slot zero.
		add_req(OP_SEARCH, '0);
		add_req(OP_SEARCH, KEY_MAX);
		add_req(OP_INSERT, KEY_MAX);
		add_req(OP_SEARCH, KEY_MAX);
		add_req(OP_INSERT, KEY_MAX);
		add_req(OP_SEARCH, KEY_W'(64));
		add_req(OP_INSERT, '0);
		add_req(OP_SEARCH, '0);
		wait_idle();

		// A size of zero acts as one slot, which is already taken.
		write_size('0);
		add_req(OP_INSERT, KEY_W'(5));
		add_req(OP_SEARCH, KEY_MAX);
		add_req(OP_SEARCH, KEY_W'(7));
		wait_idle();

		// An oversized setting is clipped to the full depth.
		write_size('1);
		add_req(OP_SEARCH, KEY_MAX);
		add_req(OP_INSERT, KEY_W'(1));
		add_req(OP_SEARCH, KEY_W'(31'h2AAA_AAAA));
		add_req(OP_INSERT, KEY_W'(31'h5555_5555));
		wait_idle();

		// Shrinking below the entry count refuses inserts but keeps searches.
		write_size(SIZE_W'(2));
		add_req(OP_INSERT, KEY_W'(6));
		add_req(OP_SEARCH, '0);
		add_req(OP_SEARCH, KEY_W'(3));
		wait_idle();

		for (p = 0; p < 18; p++) begin
			write_size(phase_sizes[p]);
			for (j = 0; j < PHASE_ITEMS; j++)
				add_req(($urandom_range(0, 99) < 45) ? OP_INSERT : OP_SEARCH, pick_key());
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (expected_rsps.size() != 0) begin
			$error("%0d predicted results never arrived", expected_rsps.size());
			error_count++;
		end
		$display("Checked %0d operations (%0d inserts, %0d searches) over %0d size settings.",
			insert_count + search_count, insert_count, search_count, size_settings + 1);
		$display("Outcomes: %0d stored, %0d refused as full, %0d found, %0d not found.",
			outcome_count[ST_INSERTED], outcome_count[ST_FULL], outcome_count[ST_FOUND],
			outcome_count[ST_NOT_FOUND]);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
